// ----- rtl/crcfd_pkg.sv -----
// shared constants, types and the byte-wide crc-32 step for the frame deframer
package crcfd_pkg;

  typedef logic [1:0]  status_t;
  typedef logic [23:0] max_len_t;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_CHECK_ERR  = 2'd1;
  localparam status_t STATUS_LENGTH_ERR = 2'd2;

  // apb map: one 32-bit register per word
  localparam int          APB_ADDR_W       = 3;
  localparam logic        REG_MAX_BODY_LEN = 1'b0;
  localparam max_len_t    MAX_BODY_LEN_RST = 24'hff_ffff;

  // header layout, byte positions
  localparam logic [3:0]  HDR_LENGTH_POS = 4'd4;
  localparam logic [3:0]  HDR_TYPE_POS   = 4'd8;
  localparam logic [3:0]  HDR_LAST_POS   = 4'd11;

  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc_checked_frame_deframer.sv -----
// top level: length-prefixed frame deframer with crc-32 check
//
//  channel   | handshake                    | word
//  ----------+------------------------------+-------------------------------------------
//  input     | in_valid / in_ready          | data_byte
//  output    | out_valid / out_ready        | payload_byte, payload_valid, message_type,
//            |                              | frame_end, status
//  config    | psel/penable/pwrite, pready  | paddr, pwdata, prdata (max_body_length)
//
// one word per cycle while nothing stalls: a word goes into the input register, is parsed
// and crc'd there and its result (if any) lands in the output register; the byte-wide crc
// step sets the cycle.
// a full, unread output register stalls only a word that makes a result; other words pass.
// rst is synchronous and clears control state; after a length or check error the
// block drops every word until reset.
module crc_checked_frame_deframer
  import crcfd_pkg::*;
#(
  parameter int LENGTH_WIDTH = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  // byte stream in
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  // results out
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            payload_byte,
  output logic                  payload_valid,
  output logic [31:0]           message_type,
  output logic                  frame_end,
  output status_t               status,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CMP_W = (LENGTH_WIDTH > 24) ? LENGTH_WIDTH : 24;

  localparam logic PHASE_HEADER = 1'b0;
  localparam logic PHASE_BODY   = 1'b1;

  max_len_t max_body_length;

  crcfd_apb_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .max_body_length (max_body_length)
  );

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // frame state
  logic                    phase, phase_next;
  logic [3:0]              header_count, header_count_next;
  logic [31:0]             received_check, received_check_next;
  logic [LENGTH_WIDTH-1:0] body_length, body_length_next;
  logic [31:0]             frame_type, frame_type_next;
  logic [LENGTH_WIDTH-1:0] body_remaining, body_remaining_next;
  logic [31:0]             crc_register, crc_register_next;
  logic                    halted, halted_next;
  logic                    length_overflow, length_overflow_next;

  // result of the word in the input register
  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_payload;
  logic       res_end;
  status_t    res_status;

  logic                    s1_advance, s1_fire, res_load;
  logic [31:0]             crc_step;
  logic [LENGTH_WIDTH+7:0] len_shift;
  logic                    check_bad;
  logic                    len_too_big;

  assign crc_step  = crc32_byte(crc_register, s1_byte);
  assign len_shift = {body_length, s1_byte};
  assign check_bad = ((crc_step ^ CRC_INIT) != received_check);
  // at the last header word the length is settled already
  assign len_too_big = length_overflow ||
                       (CMP_W'(body_length) > CMP_W'(max_body_length));

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    received_check_next  = received_check;
    body_length_next     = body_length;
    frame_type_next      = frame_type;
    body_remaining_next  = body_remaining;
    crc_register_next    = crc_register;
    halted_next          = halted;
    length_overflow_next = length_overflow;
    res_valid            = 1'b0;
    res_byte             = 8'h00;
    res_payload          = 1'b0;
    res_end              = 1'b0;
    res_status           = STATUS_OK;

    if (s1_valid && !halted) begin
      if (phase == PHASE_HEADER) begin
        header_count_next = header_count + 4'd1;
        if (header_count < HDR_LENGTH_POS) begin
          received_check_next = {received_check[23:0], s1_byte};
        end else if (header_count < HDR_TYPE_POS) begin
          body_length_next  = len_shift[LENGTH_WIDTH-1:0];
          // any set bit pushed out of the length field is an overflow
          if (len_shift[LENGTH_WIDTH+7:LENGTH_WIDTH] != 8'h00) begin
            length_overflow_next = 1'b1;
          end
          crc_register_next = crc_step;
        end else begin
          frame_type_next   = {frame_type[23:0], s1_byte};
          crc_register_next = crc_step;
        end

        if (header_count == HDR_LAST_POS) begin
          if (len_too_big) begin
            res_valid   = 1'b1;
            res_end     = 1'b1;
            res_status  = STATUS_LENGTH_ERR;
            halted_next = 1'b1;
          end else if (body_length == '0) begin
            // empty body: frame ends on the header
            res_valid            = 1'b1;
            res_end              = 1'b1;
            res_status           = check_bad ? STATUS_CHECK_ERR : STATUS_OK;
            halted_next          = check_bad;
            header_count_next    = 4'd0;
            crc_register_next    = CRC_INIT;
            length_overflow_next = 1'b0;
          end else begin
            body_remaining_next = body_length;
            phase_next          = PHASE_BODY;
          end
        end
      end else begin
        crc_register_next   = crc_step;
        body_remaining_next = body_remaining - LENGTH_WIDTH'(1);
        res_valid           = 1'b1;
        res_byte            = s1_byte;
        res_payload         = 1'b1;
        if (body_remaining_next == '0) begin
          res_end              = 1'b1;
          res_status           = check_bad ? STATUS_CHECK_ERR : STATUS_OK;
          halted_next          = check_bad;
          body_length_next     = '0;
          phase_next           = PHASE_HEADER;
          header_count_next    = 4'd0;
          crc_register_next    = CRC_INIT;
          length_overflow_next = 1'b0;
        end
      end
    end
  end

  // a word with no result never waits on the output side
  assign s1_advance = !res_valid || !out_valid || out_ready;
  assign s1_fire    = s1_valid && s1_advance;
  assign res_load   = s1_fire && res_valid;
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PHASE_HEADER;
      header_count    <= 4'd0;
      received_check  <= 32'h0;
      body_length     <= '0;
      frame_type      <= 32'h0;
      body_remaining  <= '0;
      crc_register    <= CRC_INIT;
      halted          <= 1'b0;
      length_overflow <= 1'b0;
    end else if (s1_fire) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      received_check  <= received_check_next;
      body_length     <= body_length_next;
      frame_type      <= frame_type_next;
      body_remaining  <= body_remaining_next;
      crc_register    <= crc_register_next;
      halted          <= halted_next;
      length_overflow <= length_overflow_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      payload_byte  <= res_byte;
      payload_valid <= res_payload;
      message_type  <= frame_type_next;
      frame_end     <= res_end;
      status        <= res_status;
    end
  end

  // checks

  // a final status only ever rides on the frame's last word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> status == STATUS_OK)
    else $error("non-ok status on a word that does not end the frame");

  // a word without payload is always a frame end
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid |-> frame_end)
    else $error("empty result that does not end a frame");

  // once halted, nothing more reaches the output register
  assert property (@(posedge clk) disable iff (rst)
    halted |-> !res_load)
    else $error("result produced while halted");

  // in body phase at least one body word is still due
  assert property (@(posedge clk) disable iff (rst)
    phase == PHASE_BODY |-> body_remaining != '0)
    else $error("body phase with nothing left to receive");

endmodule

// ----- rtl/crcfd_apb_regs.sv -----
// apb configuration register: maximum body length
module crcfd_apb_regs
  import crcfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output max_len_t              max_body_length
);

  logic reg_hit;

  assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_MAX_BODY_LEN);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_length <= MAX_BODY_LEN_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_body_length <= pwdata[23:0];
    end
  end

  assign prdata = reg_hit ? {8'h00, max_body_length} : 32'h0;

endmodule

// ----- tb/tb_crc_checked_frame_deframer.sv -----
// self-checking testbench for the crc-checked frame deframer
`timescale 1ns / 1ps

module tb_crc_checked_frame_deframer;
  import crcfd_pkg::*;

  // run limits and timing
  localparam int          CYCLE_LIMIT = 400_000;
  localparam int          LATENCY_PAD = 4;    // cycles let pass after the last result
  localparam int          END_PAD     = 20;
  localparam logic [3:0]  HEADER_LEN  = 4'd12;
  localparam logic [31:0] CRC_SEED    = 32'hffff_ffff;
  localparam logic [31:0] CRC_REFLECT = 32'hedb8_8320;
  localparam int          PHASES      = 5;
  localparam int          PHASE_BYTES = 210;

  // register indexes: the length limit and one index past the map
  localparam int MAX_LEN_IDX  = int'(REG_MAX_BODY_LEN);
  localparam int UNMAPPED_IDX = 1;

  // one output word of the deframer
  typedef struct packed {
    logic [7:0]  pay;
    logic        pay_valid;
    logic [31:0] mtype;
    logic        last;
    status_t     st;
  } frame_result_t;

  // directed frame: body is fill repeated body_len times
  typedef struct packed {
    logic [31:0]   mtype;
    logic [7:0]    body_len;
    logic [7:0]    fill;
    logic          typed;
    frame_result_t res;
  } lead_frame_t;

  // how the run is brought to its halting error
  typedef enum int {
    CLOSE_BAD_BODY,
    CLOSE_BAD_EMPTY,
    CLOSE_OVER_MAX,
    CLOSE_WIDE_LENGTH
  } closing_fault_t;

  // short directed opening: an empty body with an all-ones type, then a one-byte body
  // of all ones with an all-zero type; both end words are plain to read
  localparam lead_frame_t LEAD_TABLE [0:1] = '{
    '{32'hffff_ffff, 8'd0, 8'h00, 1'b1, '{8'h00, 1'b0, 32'hffff_ffff, 1'b1, STATUS_OK}},
    '{32'h0000_0000, 8'd1, 8'hff, 1'b1, '{8'hff, 1'b1, 32'h0000_0000, 1'b1, STATUS_OK}}
  };

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            data_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            payload_byte;
  logic                  payload_valid;
  logic [31:0]           message_type;
  logic                  frame_end;
  status_t               status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  crc_checked_frame_deframer u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .payload_valid(payload_valid),
    .message_type (message_type),
    .frame_end    (frame_end),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // words still owed by the block, oldest first
  frame_result_t due_words[$];
  logic [7:0]    body_q[$];

  // deframer state as the testbench sees it
  logic        in_body;
  logic [3:0]  hdr_pos;
  logic [31:0] hdr_check;
  logic [23:0] len_acc;
  logic        len_too_wide;
  logic [31:0] cur_type;
  logic [23:0] left;
  logic [31:0] crc_acc;
  logic        stopped;
  logic [23:0] max_len;

  // idling controls, set by the stimulus between frames
  int   gap_odds;
  int   ready_odds;
  logic calm;
  int   stall_left;
  int   mismatches;
  int   cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reflected crc-32 over one byte
  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_REFLECT) : (c >> 1);
    return c;
  endfunction

  task automatic start_frame();
    in_body      = 1'b0;
    hdr_pos      = '0;
    crc_acc      = CRC_SEED;
    len_too_wide = 1'b0;
    len_acc      = '0;
  endtask

  // end of a frame: compare the running crc with the header check word
  function automatic status_t close_status();
    if (~crc_acc != hdr_check) begin
      stopped = 1'b1;
      return STATUS_CHECK_ERR;
    end
    return STATUS_OK;
  endfunction

  // advance the expected deframer by one accepted byte, queueing any word it gives
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t w;
    if (stopped) return;
    if (!in_body) begin
      if (hdr_pos < 4'd4) begin
        hdr_check = {hdr_check[23:0], b};
      end else if (hdr_pos < 4'd8) begin
        // a non-zero top byte of the length word shifts out of the 24-bit length
        if (len_acc[23:16] != 8'h00) len_too_wide = 1'b1;
        len_acc = {len_acc[15:0], b};
        crc_acc = crc32_next(crc_acc, b);
      end else begin
        cur_type = {cur_type[23:0], b};
        crc_acc  = crc32_next(crc_acc, b);
      end
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos != HEADER_LEN) return;
      w = '{8'h00, 1'b0, cur_type, 1'b1, STATUS_OK};
      // length is judged before the check word
      if (len_too_wide || len_acc > max_len) begin
        stopped = 1'b1;
        w.st    = STATUS_LENGTH_ERR;
        due_words.push_back(w);
        return;
      end
      if (len_acc == '0) begin
        w.st = close_status();
        due_words.push_back(w);
        start_frame();
        return;
      end
      left    = len_acc;
      in_body = 1'b1;
    end else begin
      crc_acc = crc32_next(crc_acc, b);
      left    = left - 24'd1;
      w = '{b, 1'b1, cur_type, (left == '0), STATUS_OK};
      if (left == '0) begin
        w.st = close_status();
        start_frame();
      end
      due_words.push_back(w);
    end
  endtask

  // one byte on the input channel, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    deframe_byte(b);
  endtask

  // header (check, length, type, all big-endian) then body_q; flip spoils the check word
  task automatic send_frame(input logic [31:0] mtype, input logic [31:0] len_word,
                            input logic [31:0] flip);
    logic [31:0] crc;
    logic [31:0] check;
    crc = CRC_SEED;
    for (int i = 3; i >= 0; i--) crc = crc32_next(crc, len_word[8*i +: 8]);
    for (int i = 3; i >= 0; i--) crc = crc32_next(crc, mtype[8*i +: 8]);
    foreach (body_q[i]) crc = crc32_next(crc, body_q[i]);
    check = ~crc ^ flip;
    for (int i = 3; i >= 0; i--) send_byte(check[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len_word[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(mtype[8*i +: 8]);
    foreach (body_q[i]) send_byte(body_q[i]);
  endtask

  // hold the input until every owed word is out, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (due_words.size() == 0);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_reg(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == MAX_LEN_IDX) max_len = value[23:0];
  endtask

  // receiver: random stall bursts on out_ready, none once calm
  always @(posedge clk) begin
    if (rst || calm || ready_odds == 0) begin
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(1, ready_odds) == 1) begin
      stall_left <= $urandom_range(0, 8);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // output checker: values read here are those held before the edge
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{payload_byte, payload_valid, message_type, frame_end, status};
      if (due_words.size() == 0) begin
        if (mismatches < 10) $display("unexpected word: %p", got);
        mismatches++;
      end else begin
        want = due_words.pop_front();
        if (got.pay !== want.pay || got.pay_valid !== want.pay_valid ||
            got.mtype !== want.mtype || got.last !== want.last || got.st !== want.st) begin
          if (mismatches < 10) $display("word mismatch: expected %p, got %p", want, got);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [23:0]    limit_plan [PHASES];
    logic [23:0]    lim;
    logic [31:0]    len_word;
    logic [31:0]    flip;
    int unsigned    len;
    int             phase_bytes;
    closing_fault_t fault;

    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = '0;
    out_ready   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    gap_odds    = 0;
    ready_odds  = 0;
    calm        = 1'b0;
    stall_left  = 0;
    mismatches  = 0;
    cycle_count = 0;
    hdr_check   = '0;
    cur_type    = '0;
    left        = '0;
    stopped     = 1'b0;
    max_len     = MAX_BODY_LEN_RST;
    start_frame();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed opening, at the reset length limit; typed end words replace the predicted ones
    foreach (LEAD_TABLE[r]) begin
      body_q.delete();
      repeat (LEAD_TABLE[r].body_len) body_q.push_back(LEAD_TABLE[r].fill);
      send_frame(LEAD_TABLE[r].mtype, {24'h0, LEAD_TABLE[r].body_len}, 32'h0);
      if (LEAD_TABLE[r].typed) begin
        void'(due_words.pop_back());
        due_words.push_back(LEAD_TABLE[r].res);
      end
    end

    // limit settings: full, zero (empty bodies only), tiny, moderate, full again
    limit_plan[0] = MAX_BODY_LEN_RST;
    limit_plan[1] = 24'h0;
    limit_plan[2] = 24'($urandom_range(1, 16));
    limit_plan[3] = 24'($urandom_range(17, 300));
    limit_plan[4] = MAX_BODY_LEN_RST;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(MAX_LEN_IDX, {8'h00, limit_plan[ph]});
      // last phase: a write past the register map must leave the limit alone,
      // and both sides run without idling from here on
      if (ph == PHASES - 1) begin
        write_reg(UNMAPPED_IDX, 32'h0);
        calm = 1'b1;
      end
      lim         = limit_plan[ph];
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        if (lim == '0) begin
          len = 0;
        end else begin
          case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = (lim > 200) ? $urandom_range(40, 200) : lim;  // at the limit when it is at most 200
            default: len = $urandom_range(1, (lim < 24) ? lim : 24);
          endcase
        end
        body_q.delete();
        repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          default: gap_odds = $urandom_range(4, 9);
        endcase
        case ($urandom_range(0, 3))
          0:       ready_odds = 0;
          1:       ready_odds = 2;
          default: ready_odds = $urandom_range(4, 9);
        endcase
        send_frame($urandom, {8'h00, 24'(len)}, 32'h0);
        phase_bytes += 12 + len;
        // now and then hold off until the block has caught up
        if ($urandom_range(0, 9) == 0) drain_results();
      end
    end

    // closing frame: one halting error, chosen by the seed
    drain_results();
    fault = closing_fault_t'($urandom_range(0, 3));
    body_q.delete();
    len_word = 32'h0;
    flip     = $urandom | 32'h1;
    case (fault)
      CLOSE_BAD_BODY: begin
        len = $urandom_range(1, 8);
        repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
        len_word = len;
      end
      CLOSE_BAD_EMPTY: begin
        len_word = 32'h0;
      end
      CLOSE_OVER_MAX: begin
        lim = 24'($urandom_range(0, 1000));
        write_reg(MAX_LEN_IDX, {8'h00, lim});
        len_word = {8'h00, lim} + 32'd1;
        // a bad check word as well must not mask the length error
        if ($urandom_range(0, 1) == 0) flip = 32'h0;
      end
      CLOSE_WIDE_LENGTH: begin
        len_word = {8'($urandom_range(1, 255)), 24'($urandom)};
        if ($urandom_range(0, 1) == 0) flip = 32'h0;
      end
    endcase
    send_frame($urandom, len_word, flip);

    // halted: a sound empty frame and loose bytes must all be dropped
    body_q.delete();
    send_frame($urandom, 32'h0, 32'h0);
    repeat (8) send_byte(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    wait (due_words.size() == 0);
    repeat (END_PAD) @(posedge clk);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- crc_checked_frame_deframer.f -----
rtl/crcfd_pkg.sv
rtl/crcfd_apb_regs.sv
rtl/crc_checked_frame_deframer.sv
tb/tb_crc_checked_frame_deframer.sv
